// File: hdl/point_to_depth_image_projector_unit_assert.svh
// ----------------------------------------------------------------------------
// point_to_depth_image_projector_unit_assert.svh
// assertion macros for the depth image projector, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef POINT_TO_DEPTH_IMAGE_PROJECTOR_UNIT_ASSERT_SVH
`define POINT_TO_DEPTH_IMAGE_PROJECTOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define PTDIP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PTDIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PTDIP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define PTDIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hdl/ptdip_pkg.sv
// ----------------------------------------------------------------------------
// ptdip_pkg
// types and constants of the point to depth image projector
// ----------------------------------------------------------------------------
`default_nettype none

package ptdip_pkg;

    // image geometry
    localparam int unsigned ImageWidth  = 256;
    localparam int unsigned ImageHeight = 256;
    localparam int unsigned Pixels      = ImageWidth * ImageHeight;
    localparam int unsigned AddrW       = $clog2(Pixels);
    localparam int unsigned CoordMax    = (ImageWidth > ImageHeight) ? ImageWidth : ImageHeight;
    localparam int unsigned CoordW      = $clog2(CoordMax);
    localparam int unsigned CntW        = $clog2(CoordW + 1);

    // field widths
    localparam int unsigned PointW = 32;
    localparam int unsigned CfgW   = 24;
    localparam int unsigned IdxW   = 16;
    localparam int unsigned PixW   = 8;
    localparam int unsigned DepthW = 16;

    // datapath widths: product, numerator, dividend
    localparam int unsigned ProdW = PointW + CfgW + 1;
    localparam int unsigned RemW  = ProdW + 1;

    // operation codes
    typedef enum logic {
        OP_PROJECT = 1'b0,
        OP_READ    = 1'b1
    } t_op;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_FOCAL_X  = 2'd0,
        CFG_FOCAL_Y  = 2'd1,
        CFG_CENTER_X = 2'd2,
        CFG_CENTER_Y = 2'd3
    } t_cfg_idx;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_MEM,
        S_RD_CLR,
        S_MUL_PF,
        S_MUL_CZ,
        S_SUM,
        S_PREP,
        S_OVF,
        S_DIV,
        S_AXIS,
        S_WRITE,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

// File: hdl/point_to_depth_image_projector_unit.sv
// ----------------------------------------------------------------------------
// point_to_depth_image_projector_unit
// pinhole projection of fixed point 3D points into a cleared-on-read depth image
// ----------------------------------------------------------------------------
// usage:
//   an item (op, point_x/y/z, read_index) is taken at a rising edge with start
//   high and busy low. exactly one result per item appears on the o_ result
//   ports for one cycle with o_valid high; the receiver cannot stall it.
//   configuration (focal_x, focal_y, center_x, center_y) is written through
//   i_cfg_we / i_cfg_idx / i_cfg_data at any edge, meant while idle.
// sequence and throughput:
//   a project item multiplies, sums and divides per axis when both axes are
//   in the image (one shared 32x25 multiplier and one shift-subtract divider
//   step per cycle, 8 quotient bits per axis), and ends early when an axis
//   falls out. a point with no positive depth goes straight to the result.
//   the next item is taken the cycle after the result strobe.
// reset:
//   synchronous, active low. after reset the depth store is swept to zero one
//   pixel a cycle with busy high; config writes still land.
// ----------------------------------------------------------------------------
`default_nettype none

`include "point_to_depth_image_projector_unit_assert.svh"

module point_to_depth_image_projector_unit
    import ptdip_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // command channel
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic                     i_op,
    input  wire logic signed [PointW-1:0] i_point_x,
    input  wire logic signed [PointW-1:0] i_point_y,
    input  wire logic signed [PointW-1:0] i_point_z,
    input  wire logic [IdxW-1:0]          i_read_index,
    // configuration write port
    input  wire logic                     i_cfg_we,
    input  wire logic [1:0]               i_cfg_idx,
    input  wire logic [CfgW-1:0]          i_cfg_data,
    // result channel
    output logic                          o_valid,
    output logic                          o_kept,
    output logic                          o_in_bounds,
    output logic [PixW-1:0]               o_pixel_col,
    output logic [PixW-1:0]               o_pixel_row,
    output logic [DepthW-1:0]             o_depth_out
);

    localparam logic [CoordW:0] LimX = (CoordW + 1)'(ImageWidth - 1);
    localparam logic [CoordW:0] LimY = (CoordW + 1)'(ImageHeight - 1);

    // sequencer
    t_state r_state, n_state;

    // configuration registers
    logic [CfgW-1:0] r_focal_x, r_focal_y, r_center_x, r_center_y;

    // item registers
    logic signed [PointW-1:0] r_x, r_y, r_z;
    logic [IdxW-1:0]          r_idx;

    // arithmetic registers
    logic signed [ProdW-1:0] r_prod, r_num;
    logic [RemW-1:0]         r_rem, r_dsh;
    logic [CoordW-1:0]       r_q, r_col, r_row;
    logic [CntW-1:0]         r_cnt;
    logic                    r_neg, r_axis;

    // clear sweep and store
    logic [AddrW-1:0]  r_clr;
    logic [DepthW-1:0] r_mem [Pixels];
    logic [DepthW-1:0] r_rdata;

    // result registers
    logic              r_kept, r_in_bounds;
    logic [PixW-1:0]   r_col_o, r_row_o;
    logic [DepthW-1:0] r_depth_o;

    // combinational controls
    logic                     w_accept;
    logic                     w_mul_z, w_mul_c;
    logic signed [PointW-1:0] w_mul_a;
    logic [CfgW-1:0]          w_mul_b;
    logic signed [ProdW-1:0]  w_prod;
    logic [ProdW-1:0]         w_mag;
    logic                     w_ge;
    logic                     w_axis_ok;
    logic [CoordW:0]          w_lim;
    logic                     w_idx_ok;
    logic                     w_mem_we;
    logic [AddrW-1:0]         w_mem_waddr, w_mem_raddr, w_pix_addr;
    logic [DepthW-1:0]        w_mem_wdata, w_depth;
    logic [PointW:0]          w_zr;

    assign w_accept = start && !busy;
    assign w_idx_ok = 32'(i_read_index) < Pixels;

    // shared multiplier: point or depth times focal or center
    assign w_mul_a = w_mul_z ? r_z : (r_axis ? r_y : r_x);
    assign w_mul_b = w_mul_c ? (r_axis ? r_center_y : r_center_x)
                             : (r_axis ? r_focal_y : r_focal_x);
    assign w_prod  = w_mul_a * $signed({1'b0, w_mul_b});

    // magnitude of numerator, divider compare, axis range check
    assign w_mag     = r_num[ProdW-1] ? ProdW'(-r_num) : ProdW'(r_num);
    assign w_ge      = r_rem >= r_dsh;
    assign w_lim     = r_axis ? LimY : LimX;
    assign w_axis_ok = !(r_neg && (r_q != '0)) && ((CoordW + 1)'(r_q) <= w_lim);

    // pixel address and rounded, saturated depth
    assign w_pix_addr = AddrW'(32'(r_row) * ImageWidth + 32'(r_col));
    assign w_zr       = (PointW + 1)'(r_z) + (PointW + 1)'(128);
    assign w_depth    = (|w_zr[PointW:DepthW + 8]) ? {DepthW{1'b1}} : w_zr[DepthW + 7:8];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == AddrW'(Pixels - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_op == OP_READ) n_state = w_idx_ok ? S_RD_MEM : S_FINISH;
                    else if (i_point_z > 0) n_state = S_MUL_PF;
                    else n_state = S_FINISH;
                end
            end
            S_RD_MEM: n_state = S_RD_CLR;
            S_RD_CLR: n_state = S_FINISH;
            S_MUL_PF: n_state = S_MUL_CZ;
            S_MUL_CZ: n_state = S_SUM;
            S_SUM:    n_state = S_PREP;
            S_PREP:   n_state = S_OVF;
            S_OVF: begin
                n_state = w_ge ? S_FINISH : S_DIV;
            end
            S_DIV: begin
                if (r_cnt == CntW'(1)) n_state = S_AXIS;
            end
            S_AXIS: begin
                if (!w_axis_ok) n_state = S_FINISH;
                else if (!r_axis) n_state = S_MUL_PF;
                else n_state = S_WRITE;
            end
            S_WRITE:  n_state = S_FINISH;
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    // state outputs: handshake, multiplier operands, store write port
    always_comb begin
        busy        = (r_state != S_IDLE);
        o_valid     = (r_state == S_FINISH);
        w_mul_z     = 1'b0;
        w_mul_c     = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_waddr = w_pix_addr;
        w_mem_wdata = w_depth;
        w_mem_raddr = AddrW'(r_idx);
        case (r_state)
            S_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr;
                w_mem_wdata = '0;
            end
            S_MUL_CZ: begin
                w_mul_z = 1'b1;
                w_mul_c = 1'b1;
            end
            S_RD_CLR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = AddrW'(r_idx);
                w_mem_wdata = '0;
            end
            S_WRITE: begin
                w_mem_we = 1'b1;
            end
            default: begin
                w_mem_we = 1'b0;
            end
        endcase
    end

    // state register and clear sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + AddrW'(1);
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= CfgW'(256);
            r_focal_y  <= CfgW'(256);
            r_center_x <= '0;
            r_center_y <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FOCAL_X:  r_focal_x  <= i_cfg_data;
                CFG_FOCAL_Y:  r_focal_y  <= i_cfg_data;
                CFG_CENTER_X: r_center_x <= i_cfg_data;
                CFG_CENTER_Y: r_center_y <= i_cfg_data;
                default:      r_focal_x  <= r_focal_x;
            endcase
        end
    end

    // depth store, registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[w_mem_waddr] <= w_mem_wdata;
        r_rdata <= r_mem[w_mem_raddr];
    end

    // datapath: multiply, accumulate, shift-subtract divide, results
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_x         <= i_point_x;
                r_y         <= i_point_y;
                r_z         <= i_point_z;
                r_idx       <= i_read_index;
                r_axis      <= 1'b0;
                r_kept      <= (i_op == OP_PROJECT) && (i_point_z > 0);
                r_in_bounds <= 1'b0;
                r_col_o     <= '0;
                r_row_o     <= '0;
                r_depth_o   <= '0;
            end
            S_RD_CLR: begin
                r_depth_o <= r_rdata;
            end
            S_MUL_PF: begin
                r_prod <= w_prod;
            end
            S_MUL_CZ: begin
                r_num  <= r_prod;
                r_prod <= w_prod;
            end
            S_SUM: begin
                r_num <= r_num + r_prod;
            end
            S_PREP: begin
                // dividend 2|num| + 256z, divisor 512z aligned one above the top quotient bit
                r_rem <= {w_mag, 1'b0} + (RemW'(r_z) << 8);
                r_dsh <= RemW'(r_z) << (9 + CoordW);
                r_neg <= r_num[ProdW-1];
                r_q   <= '0;
                r_cnt <= CntW'(CoordW);
            end
            S_OVF: begin
                r_dsh <= r_dsh >> 1;
            end
            S_DIV: begin
                if (w_ge) r_rem <= r_rem - r_dsh;
                r_q   <= {r_q[CoordW-2:0], w_ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - CntW'(1);
            end
            S_AXIS: begin
                if (r_axis) r_row <= r_q;
                else r_col <= r_q;
                r_axis <= 1'b1;
            end
            S_WRITE: begin
                r_in_bounds <= 1'b1;
                r_col_o     <= r_col[PixW-1:0];
                r_row_o     <= r_row[PixW-1:0];
            end
            default: begin
                r_axis <= r_axis;
            end
        endcase
    end

    assign o_kept      = r_kept;
    assign o_in_bounds = r_in_bounds;
    assign o_pixel_col = r_col_o;
    assign o_pixel_row = r_row_o;
    assign o_depth_out = r_depth_o;

    // checks
    `PTDIP_ASSERT_NEXT(a_valid_one_cycle, i_clk, i_rst_n, o_valid, !o_valid, "result strobe longer than one cycle")
    `PTDIP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, start && !busy, busy, "not busy after item accept")
    `PTDIP_ASSERT_NOW(a_inb_needs_kept, i_clk, i_rst_n, o_valid && o_in_bounds, o_kept, "in_bounds without kept")
    `PTDIP_ASSERT_NOW(a_kept_no_depth, i_clk, i_rst_n, o_valid && o_kept, o_depth_out == '0, "depth on a project item")
    `PTDIP_ASSERT_NOW(a_div_count, i_clk, i_rst_n, r_state == S_DIV, r_cnt != '0, "divider ran past its last step")

endmodule

`default_nettype wire
